[hw/rtl/bgq_pkg.sv]
// ----------------------------------------------------------------------------
// bgq_pkg
// Shared widths, register indexes, types and unorm helpers for the bilinear
// gradient pixel unit.
// ----------------------------------------------------------------------------
package bgq_pkg;

  // field widths
  localparam int CH_W   = 8;
  localparam int RGBA_W = 4 * CH_W;
  localparam int POS_W  = 12;
  localparam int DIM_W  = 13;
  localparam int FRAC_W = 16;
  localparam int WGT_W  = FRAC_W + 1;
  localparam int EDGE_W = CH_W + FRAC_W;
  localparam int ACC_W  = EDGE_W + WGT_W;
  localparam int IDX_W  = 3;

  // largest rectangle side taken as is, larger values are clamped to it
  localparam int MAX_DIM = 4096;

  // default number of quotient bits resolved per divider stage
  localparam int DIV_PER_STAGE_DEF = 3;

  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

  typedef logic [IDX_W-1:0]  cfg_idx_t;
  typedef logic [RGBA_W-1:0] rgba_t;
  typedef logic [CH_W-1:0]   chan_t;
  // index 0 red, 1 green, 2 blue, 3 alpha
  typedef chan_t [3:0]       chan4_t;
  // index 0 top-left, 1 top-right, 2 bottom-right, 3 bottom-left
  typedef chan4_t [3:0]      corner_set_t;

  localparam cfg_idx_t CFG_CORNER_TL = 3'd0;
  localparam cfg_idx_t CFG_CORNER_TR = 3'd1;
  localparam cfg_idx_t CFG_CORNER_BR = 3'd2;
  localparam cfg_idx_t CFG_CORNER_BL = 3'd3;
  localparam cfg_idx_t CFG_TINT      = 3'd4;
  localparam cfg_idx_t CFG_WIDTH     = 3'd5;
  localparam cfg_idx_t CFG_HEIGHT    = 3'd6;

  localparam int CH_ALPHA = 3;

  // channel k of a packed word, red in the top byte
  function automatic chan_t get_chan(input rgba_t w, input logic [1:0] k);
    rgba_t sh;
    sh = w >> {~k, 3'b000};
    return sh[CH_W-1:0];
  endfunction

  // round(a * b / 255) without a divider, exact for the whole 8-bit range
  function automatic chan_t mul_unorm(input chan_t a, input chan_t b);
    logic [16:0] t;
    logic [16:0] q;
    t = 17'(a) * 17'(b) + 17'd127;
    q = (t + 17'(t[16:8]) + 17'd1) >> 8;
    return q[CH_W-1:0];
  endfunction

endpackage

[hw/rtl/bgq_if.sv]
// ----------------------------------------------------------------------------
// bgq channels
// Valid/ready channels for pixel requests, pixel results and register writes.
// ----------------------------------------------------------------------------
interface bgq_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bgq_pkg::POS_W-1:0]   pixel_x;
  logic [bgq_pkg::POS_W-1:0]   pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface bgq_rgba_if;
  logic                        valid;
  logic                        ready;
  logic [bgq_pkg::CH_W-1:0]    out_red;
  logic [bgq_pkg::CH_W-1:0]    out_green;
  logic [bgq_pkg::CH_W-1:0]    out_blue;
  logic [bgq_pkg::CH_W-1:0]    out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface bgq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bgq_pkg::IDX_W-1:0]   index;
  logic [bgq_pkg::RGBA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/bgq_corner.sv]
// ----------------------------------------------------------------------------
// bgq_corner
// Tints the four corner colours and premultiplies them by their alpha, two
// register stages, free running off the configuration registers.
// ----------------------------------------------------------------------------
module bgq_corner (
  input  logic                      clk,
  input  bgq_pkg::rgba_t [3:0]      corners_i,
  input  bgq_pkg::rgba_t            tint_i,
  output bgq_pkg::corner_set_t      prem_o
);

  bgq_pkg::corner_set_t tinted_r;
  bgq_pkg::corner_set_t prem_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        tinted_r[c][k] <= bgq_pkg::mul_unorm(bgq_pkg::get_chan(corners_i[c], 2'(k)),
                                             bgq_pkg::get_chan(tint_i, 2'(k)));
      end
    end
  end

  // alpha passes, colour channels are scaled by the tinted alpha
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        if (k == bgq_pkg::CH_ALPHA) begin
          prem_r[c][k] <= tinted_r[c][bgq_pkg::CH_ALPHA];
        end else begin
          prem_r[c][k] <= bgq_pkg::mul_unorm(tinted_r[c][k], tinted_r[c][bgq_pkg::CH_ALPHA]);
        end
      end
    end
  end

  assign prem_o = prem_r;

endmodule

[hw/rtl/bgq_divider.sv]
// ----------------------------------------------------------------------------
// bgq_divider
// Pipelined restoring divider for one weight: (pos << 16) / last, with pos
// clamped to last, PER_STAGE quotient bits per stage.
// ----------------------------------------------------------------------------
module bgq_divider #(
  parameter int PER_STAGE = bgq_pkg::DIV_PER_STAGE_DEF,
  parameter int STAGES    = (bgq_pkg::WGT_W + PER_STAGE - 1) / PER_STAGE
) (
  input  logic                       clk,
  input  logic [STAGES-1:0]          en_i,
  input  logic [bgq_pkg::POS_W-1:0]  pos_i,
  input  logic [bgq_pkg::DIM_W-1:0]  last_i,
  output logic [bgq_pkg::WGT_W-1:0]  quo_o
);

  localparam int DW = bgq_pkg::DIM_W;
  localparam int QW = bgq_pkg::WGT_W;

  logic [DW-1:0] rem_r [STAGES];
  logic [QW-1:0] quo_r [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stg
    logic [DW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (j == 0) begin : g_first
      // coordinates beyond the last column or row saturate the weight at one
      assign rem_in = (DW'(pos_i) > last_i) ? last_i : DW'(pos_i);
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    always_comb begin
      logic [DW:0] r;
      r       = '0;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int s = 0; s < PER_STAGE; s++) begin
        if (j * PER_STAGE + s < QW) begin
          // first step settles the integer bit, the rest shift in a zero
          if (j * PER_STAGE + s == 0) begin
            r = {1'b0, rem_nxt};
          end else begin
            r = {rem_nxt, 1'b0};
          end
          if (r >= {1'b0, last_i}) begin
            quo_nxt = {quo_nxt[QW-2:0], 1'b1};
            rem_nxt = DW'(r - {1'b0, last_i});
          end else begin
            quo_nxt = {quo_nxt[QW-2:0], 1'b0};
            rem_nxt = r[DW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en_i[j]) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[STAGES-1];

endmodule

[hw/rtl/bilinear_gradient_quad_pixel_unit.sv]
// ----------------------------------------------------------------------------
// bilinear_gradient_quad_pixel_unit
// One pixel of a tinted, premultiplied bilinear gradient rectangle per clock while out_px is ready.
// ----------------------------------------------------------------------------
//
//   channel   dir  payload                                   request taken when
//   in_px     in   pixel_x, pixel_y                          valid && ready
//   out_px    out  out_red, out_green, out_blue, out_alpha   valid && ready
//   cfg_wr    in   index, data                               valid (ready held high)
//
// One pixel per cycle sustained while out_px is ready; the stages are the request
// register, the weight dividers at DIV_PER_STAGE quotient bits per stage, then
// the two interpolation multiply stages.
// Corner tint and premultiply settle through the bgq_corner registers after a register write.
// Reset clears the valid bits and loads the register reset values.
// A stall on out_px holds the last stage; earlier stages keep filling bubbles.
// ----------------------------------------------------------------------------
module bilinear_gradient_quad_pixel_unit #(
  parameter int DIV_PER_STAGE = bgq_pkg::DIV_PER_STAGE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  bgq_pix_if.sink            in_px,
  bgq_rgba_if.source         out_px,
  bgq_cfg_if.sink            cfg_wr
);

  localparam int DW         = bgq_pkg::DIM_W;
  localparam int QW         = bgq_pkg::WGT_W;
  localparam int EW         = bgq_pkg::EDGE_W;
  localparam int AW         = bgq_pkg::ACC_W;
  localparam int DIV_STAGES = (QW + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int STG_A      = 1 + DIV_STAGES;
  localparam int NSTG       = STG_A + 2;

  // configuration registers
  bgq_pkg::rgba_t [3:0] corner_r;
  bgq_pkg::rgba_t       tint_r;
  logic [DW-1:0]        width_r;
  logic [DW-1:0]        height_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= '0;
      tint_r   <= '1;
      width_r  <= DW'(1);
      height_r <= DW'(1);
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        bgq_pkg::CFG_CORNER_TL: corner_r[0] <= cfg_wr.data;
        bgq_pkg::CFG_CORNER_TR: corner_r[1] <= cfg_wr.data;
        bgq_pkg::CFG_CORNER_BR: corner_r[2] <= cfg_wr.data;
        bgq_pkg::CFG_CORNER_BL: corner_r[3] <= cfg_wr.data;
        bgq_pkg::CFG_TINT:      tint_r      <= cfg_wr.data;
        bgq_pkg::CFG_WIDTH:     width_r     <= cfg_wr.data[DW-1:0];
        bgq_pkg::CFG_HEIGHT:    height_r    <= cfg_wr.data[DW-1:0];
        default: ;
      endcase
    end
  end

  // divisors and flat-axis flags derived from the dimensions
  logic [DW-1:0] dim_x, dim_y;
  logic          zero_x_nxt, zero_y_nxt;
  logic [DW-1:0] last_x_nxt, last_y_nxt;
  logic          zero_x_r, zero_y_r;
  logic [DW-1:0] last_x_r, last_y_r;

  always_comb begin
    dim_x      = (32'(width_r) > 32'(bgq_pkg::MAX_DIM)) ? DW'(bgq_pkg::MAX_DIM) : width_r;
    dim_y      = (32'(height_r) > 32'(bgq_pkg::MAX_DIM)) ? DW'(bgq_pkg::MAX_DIM) : height_r;
    zero_x_nxt = (dim_x <= DW'(1));
    zero_y_nxt = (dim_y <= DW'(1));
    last_x_nxt = zero_x_nxt ? '0 : dim_x - DW'(1);
    last_y_nxt = zero_y_nxt ? '0 : dim_y - DW'(1);
  end

  always_ff @(posedge clk) begin
    zero_x_r <= zero_x_nxt;
    zero_y_r <= zero_y_nxt;
    last_x_r <= last_x_nxt;
    last_y_r <= last_y_nxt;
  end

  bgq_pkg::corner_set_t prem;

  bgq_corner u_corner (
    .clk       (clk),
    .corners_i (corner_r),
    .tint_i    (tint_r),
    .prem_o    (prem)
  );

  // stage valids and per-stage advance, bubbles collapse towards the output
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_px.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_px.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_px.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // stage 0: request register
  logic [bgq_pkg::POS_W-1:0] x_r, y_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r <= in_px.pixel_x;
      y_r <= in_px.pixel_y;
    end
  end

  logic [QW-1:0] quo_x, quo_y;

  bgq_divider #(.PER_STAGE(DIV_PER_STAGE), .STAGES(DIV_STAGES)) u_div_x (
    .clk    (clk),
    .en_i   (en[1 +: DIV_STAGES]),
    .pos_i  (x_r),
    .last_i (last_x_r),
    .quo_o  (quo_x)
  );

  bgq_divider #(.PER_STAGE(DIV_PER_STAGE), .STAGES(DIV_STAGES)) u_div_y (
    .clk    (clk),
    .en_i   (en[1 +: DIV_STAGES]),
    .pos_i  (y_r),
    .last_i (last_y_r),
    .quo_o  (quo_y)
  );

  logic [QW-1:0] wx, wy, inv_wy;

  assign wx     = zero_x_r ? '0 : quo_x;
  assign wy     = zero_y_r ? '0 : quo_y;
  assign inv_wy = bgq_pkg::WGT_ONE - wy;

  // stage A: left and right edge values, 8.16
  logic [EW-1:0] left_nxt  [4];
  logic [EW-1:0] right_nxt [4];
  logic [EW-1:0] left_r    [4];
  logic [EW-1:0] right_r   [4];
  logic [QW-1:0] wx_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      left_nxt[k]  = EW'(EW'(prem[0][k]) * EW'(inv_wy) + EW'(prem[3][k]) * EW'(wy));
      right_nxt[k] = EW'(EW'(prem[1][k]) * EW'(inv_wy) + EW'(prem[2][k]) * EW'(wy));
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_A]) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      wx_r    <= wx;
    end
  end

  // stage B: blend across, keep the integer byte
  logic [QW-1:0]           inv_wx;
  logic [AW-1:0]           acc [4];
  bgq_pkg::chan4_t         pix_nxt;
  bgq_pkg::chan4_t         pix_r;

  assign inv_wx = bgq_pkg::WGT_ONE - wx_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k]     = AW'(left_r[k]) * AW'(inv_wx) + AW'(right_r[k]) * AW'(wx_r);
      pix_nxt[k] = acc[k][2*bgq_pkg::FRAC_W +: bgq_pkg::CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_px.valid     = v_r[NSTG-1];
  assign out_px.out_red   = pix_r[0];
  assign out_px.out_green = pix_r[1];
  assign out_px.out_blue  = pix_r[2];
  assign out_px.out_alpha = pix_r[3];

  // back-pressure reaches the input only when every stage holds a request
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_px.ready |-> (&v_r))
    else $error("input stalled while the pipeline has a bubble");

  // premultiplied colour never exceeds alpha after interpolation
  a_premul: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-1] |-> (pix_r[0] <= pix_r[3]) && (pix_r[1] <= pix_r[3])
                    && (pix_r[2] <= pix_r[3]))
    else $error("colour channel above alpha");

  // a rectangle with both sides zero or one gives the top-left corner as it is
  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-1] && zero_x_r && zero_y_r |-> (pix_r == prem[0]))
    else $error("flat rectangle differs from top-left corner");

endmodule

[test/tb_bilinear_gradient_quad_pixel_unit.sv]
// ----------------------------------------------------------------------------
// tb_bilinear_gradient_quad_pixel_unit
// Drives pixel requests and register writes into the gradient pixel unit and
// checks every returned pixel against a bit-exact software predictor of the
// tint, premultiply and bilinear interpolation, under random back-pressure.
// ----------------------------------------------------------------------------
module tb_bilinear_gradient_quad_pixel_unit;
  import bgq_pkg::*;

  // write to an index past the register list, must be dropped
  localparam cfg_idx_t CFG_UNUSED = 3'd7;
  localparam int PIPE_LAT = 9;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQUESTS = 122;

  class gradient_scoreboard;
    rgba_t       corner[4];   // 0 top-left, 1 top-right, 2 bottom-right, 3 bottom-left
    rgba_t       tint;
    logic [12:0] width;
    logic [12:0] height;
    chan4_t      pending_pixels[$];
    int          errors;
    string       chan_name[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

    function new();
      corner = '{default: '0};
      tint   = 32'hFFFF_FFFF;
      width  = 13'd1;
      height = 13'd1;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, rgba_t data);
      case (idx)
        CFG_CORNER_TL: corner[0] = data;
        CFG_CORNER_TR: corner[1] = data;
        CFG_CORNER_BR: corner[2] = data;
        CFG_CORNER_BL: corner[3] = data;
        CFG_TINT:      tint = data;
        CFG_WIDTH:     width = data[DIM_W-1:0];
        CFG_HEIGHT:    height = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function chan_t unorm_mul(chan_t a, chan_t b);
      int unsigned p;
      p = (int'(a) * int'(b) + 127) / 255;
      return p[CH_W-1:0];
    endfunction

    // tinted and premultiplied channel k of one corner
    function chan_t shaded_corner(rgba_t c, int k);
      chan_t ma;
      ma = unorm_mul(c[CH_W-1:0], tint[CH_W-1:0]);
      if (k == CH_ALPHA) return ma;
      return unorm_mul(unorm_mul(c[31-8*k -: 8], tint[31-8*k -: 8]), ma);
    endfunction

    function longint unsigned axis_weight(logic [POS_W-1:0] pos, logic [12:0] dim);
      longint unsigned d;
      longint unsigned p;
      d = 64'(dim);
      if (d > 64'(MAX_DIM)) d = 64'(MAX_DIM);
      if (d <= 64'd1) return 64'd0;
      p = 64'(pos);
      if (p > d - 64'd1) p = d - 64'd1;
      return (p << FRAC_W) / (d - 64'd1);
    endfunction

    function chan4_t gradient_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
      longint unsigned wx;
      longint unsigned wy;
      longint unsigned c[4];
      longint unsigned left;
      longint unsigned right;
      longint unsigned v;
      chan4_t px;
      wx = axis_weight(x, width);
      wy = axis_weight(y, height);
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) c[j] = 64'(shaded_corner(corner[j], k));
        left  = c[0] * (64'd65536 - wy) + c[3] * wy;
        right = c[1] * (64'd65536 - wy) + c[2] * wy;
        v = (left * (64'd65536 - wx) + right * wx) >> 32;
        px[k] = v[CH_W-1:0];
      end
      return px;
    endfunction

    function void note_request(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
      pending_pixels.push_back(gradient_pixel(x, y));
    endfunction

    function void check_pixel(chan4_t got);
      chan4_t want;
      if (pending_pixels.size() == 0) begin
        $error("pixel result with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got[k] !== want[k]) begin
          $error("%s: expected %0d, got %0d", chan_name[k], want[k], got[k]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bgq_pix_if  pix ();
  bgq_rgba_if rgb ();
  bgq_cfg_if  cfg ();

  gradient_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_output;

  bilinear_gradient_quad_pixel_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (pix),
    .out_px (rgb),
    .cfg_wr (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= x;
    pix.pixel_y <= y;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sb.note_request(x, y);
  endtask

  // stop offering and wait for every outstanding pixel to come back
  task automatic drain_pixels();
    pix.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input rgba_t data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(input rgba_t tl, input rgba_t tr, input rgba_t br,
                               input rgba_t bl, input rgba_t tint, input rgba_t w,
                               input rgba_t h);
    drain_pixels();
    repeat (PIPE_LAT + 3) @(posedge clk);
    write_reg(CFG_CORNER_TL, tl);
    write_reg(CFG_CORNER_TR, tr);
    write_reg(CFG_CORNER_BR, br);
    write_reg(CFG_CORNER_BL, bl);
    write_reg(CFG_TINT, tint);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg.valid <= 1'b0;
    // corner shading settles through the tint and premultiply registers after a write
    repeat (4) @(posedge clk);
  endtask

  function automatic rgba_t random_colour();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic rgba_t random_dim();
    rgba_t d;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: d = $urandom_range(16, 1);
      5, 6:          d = $urandom_range(MAX_DIM, 1);
      7:             d = $urandom_range(8191, 0);
      default: begin
        case ($urandom_range(4))
          0:       d = 0;
          1:       d = 1;
          2:       d = 2;
          3:       d = MAX_DIM;
          default: d = 8191;
        endcase
      end
    endcase
    // junk above the register width is dropped by the block
    if ($urandom_range(1) == 1) d = d | ($urandom & 32'hFFFF_E000);
    return d;
  endfunction

  function automatic logic [POS_W-1:0] random_pos(input rgba_t dim);
    int unsigned span;
    span = 32'(dim[DIM_W-1:0]);
    if (span > MAX_DIM) span = MAX_DIM;
    if (span < 1) span = 1;
    case ($urandom_range(9))
      0, 1:    return POS_W'($urandom_range(4095));
      2:       return POS_W'(span - 1);
      default: return POS_W'($urandom_range(span - 1));
    endcase
  endfunction

  task automatic random_phase(input int n, input bit pause_midway);
    rgba_t w;
    rgba_t h;
    rgba_t tint;
    w = random_dim();
    h = random_dim();
    tint = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF : random_colour();
    apply_setting(random_colour(), random_colour(), random_colour(), random_colour(),
                  tint, w, h);
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain_pixels();
      send_pixel(random_pos(w), random_pos(h));
    end
  endtask

  // result side: checks each accepted pixel and throttles ready
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    rgb.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rgb.valid && rgb.ready)
        sb.check_pixel({rgb.out_alpha, rgb.out_blue, rgb.out_green, rgb.out_red});
      if (hold_output) begin
        hold_output = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        rgb.ready <= 1'b0;
      end else begin
        rgb.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_output = 1'b0;
    pix.valid   <= 1'b0;
    pix.pixel_x <= '0;
    pix.pixel_y <= '0;
    cfg.valid   <= 1'b0;
    cfg.index   <= CFG_CORNER_TL;
    cfg.data    <= '0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // saturated corners, exact corner hits and requests outside the rectangle
    apply_setting(32'hFFFF_FFFF, 32'hFF00_00FF, 32'h00FF_00FF, 32'h0000_FF80,
                  32'hFFFF_FFFF, 32'd8, 32'd4);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    cfg.valid <= 1'b0;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd7, 12'd0);
    send_pixel(12'd7, 12'd3);
    send_pixel(12'd0, 12'd3);
    send_pixel(12'd3, 12'd2);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd8, 12'd1);

    // zero width and unit height: both weights forced to zero
    apply_setting(32'h10FF_7FC0, 32'hFF80_20FF, 32'h40C0_FF7F, 32'hA05A_33E0,
                  32'h80FF_40C0, 32'd0, 32'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2730, 12'd1365);

    // width above the limit, height at the limit with high junk bits in the height word
    apply_setting(32'hFFFF_FFFF, 32'h0000_00FF, 32'hFF00_FFFF, 32'h00FF_FF7F,
                  32'hFFFF_FFFF, 32'h0000_1FFF, 32'hFFFF_F000);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd1);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd1365, 12'd2730);

    // fully transparent tint
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h0000_0000, 32'd2, 32'd2);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd0, 12'd0);

    // zero corner alpha wipes colour
    apply_setting(32'h1234_5600, 32'hFFFF_FF00, 32'h89AB_CDEF, 32'hFEDC_BA98,
                  32'hFFFF_FFFF, 32'd3, 32'd65);
    send_pixel(12'd2, 12'd64);
    send_pixel(12'd1, 12'd32);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 73;
      end else if (p < 4) begin
        send_idle_pct = 73;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 4) begin
        random_phase(0, 1'b0);
        // long output stall while requests keep coming
        hold_output = 1'b1;
        for (int i = 0; i < PHASE_REQUESTS; i++)
          send_pixel(random_pos(32'd16), random_pos(32'd16));
      end else begin
        random_phase(PHASE_REQUESTS, p == 5);
      end
    end

    drain_pixels();
    repeat (PIPE_LAT + 11) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("simulation failed");
    $finish;
  end

endmodule

[bilinear_gradient_quad_pixel_unit.f]
hw/rtl/bgq_pkg.sv
hw/rtl/bgq_if.sv
hw/rtl/bgq_corner.sv
hw/rtl/bgq_divider.sv
hw/rtl/bilinear_gradient_quad_pixel_unit.sv
test/tb_bilinear_gradient_quad_pixel_unit.sv
